// File: hw/rtl/bfs_reachability_engine_assert.svh
// Assertion macros for the breadth-first reachability engine.
// Used by the RTL files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef BFS_REACHABILITY_ENGINE_ASSERT_SVH
`define BFS_REACHABILITY_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset
`define BRE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
// Condition must never be true at a clock edge outside reset
`define BRE_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);
`else
`define BRE_ASSERT(lbl, prop, msg)
`define BRE_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// File: hw/rtl/bre_pkg.sv
// Shared types and constants of the breadth-first reachability engine.
// No dependencies; imported by the controller, datapath and top level.
package bre_pkg;

    localparam int NODE_W = 6;
    localparam int ROW_W  = 64;
    localparam int CNT_W  = 7;
    localparam logic [CNT_W-1:0] NODE_COUNT_RST = 7'd64;

    // Input word opcodes; the fourth code is unused
    typedef enum logic [1:0] {
        CMD_LOAD     = 2'd0,
        CMD_TRAVERSE = 2'd1,
        CMD_CONNECT  = 2'd2
    } bre_cmd_t;

    // Kind of result word the datapath builds
    typedef enum logic [1:0] {
        OUT_NODE,
        OUT_CONN,
        OUT_ERR
    } bre_out_kind_t;

    typedef struct packed {
        bre_cmd_t            command;
        logic [NODE_W-1:0]   row_index;
        logic [ROW_W-1:0]    row_bits;
        logic [NODE_W-1:0]   start_node;
    } bre_item_t;

    typedef struct packed {
        logic [NODE_W-1:0]   node;
        logic                last;
        logic                connected;
        logic                error;
    } bre_result_t;

    // Controller to datapath commands
    typedef struct packed {
        logic           load_adj;
        logic           init_run;
        logic           src_zero;
        logic           deq;
        logic           latch_cur;
        logic           take_row;
        logic           push;
        logic           load_out;
        bre_out_kind_t  out_kind;
    } bre_ctl_t;

    // Datapath to controller status
    typedef struct packed {
        bre_cmd_t  cmd;
        logic      start_ok;
        logic      queue_empty;
        logic      pending_zero;
        logic      out_free;
    } bre_sts_t;

    // Mask with the lowest n bits set
    function automatic logic [ROW_W-1:0] low_mask(input logic [CNT_W-1:0] n);
        logic [ROW_W-1:0] m;
        m = '0;
        for (int i = 0; i < ROW_W; i++)
        begin
            m[i] = (CNT_W'(i) < n);
        end
        return m;
    endfunction

endpackage

// File: hw/rtl/bfs_reachability_engine.sv
// Breadth-first reachability engine over an adjacency bit matrix.
// Load word: no result. Error word: the error state loads the result register. Search:
// accepted in idle, then per reached node a queue RAM read (DEQ), an adjacency RAM read (ADJ),
// a take of the fresh neighbors (FRESH) and a scan that pushes each of them (SCAN); traversal
// emits each node (EMIT), connectivity ends with its verdict (CONN); these wait on result_ready.
// Reset (rst_n, async low) clears the queue pointers, visited bits and sets node_count to 64;
// adjacency rows and queue entries are undefined until written.
module bfs_reachability_engine #(
    parameter int MAX_NODES = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      node_count_we,
    input  logic [bre_pkg::CNT_W-1:0] node_count_wdata,
    input  logic                      item_valid,
    output logic                      item_ready,
    input  bre_pkg::bre_item_t        item,
    output logic                      result_valid,
    input  logic                      result_ready,
    output bre_pkg::bre_result_t      result
);
    import bre_pkg::*;

    bre_ctl_t ctl;
    bre_sts_t sts;

    // Sequencer
    bre_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .sts        (sts),
        .ctl        (ctl)
    );

    // Storage and search datapath
    bre_dp #(
        .MAX_NODES (MAX_NODES)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .node_count_we    (node_count_we),
        .node_count_wdata (node_count_wdata),
        .item             (item),
        .result           (result),
        .result_valid     (result_valid),
        .result_ready     (result_ready),
        .ctl              (ctl),
        .sts              (sts)
    );

endmodule

// File: hw/rtl/bre_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module bre_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/bre_ctrl.sv
// Sequencer of the reachability engine: decodes input words and steps each search.
// Depends on bre_pkg; drives the datapath through bre_ctl_t and reads bre_sts_t.
module bre_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  bre_pkg::bre_sts_t sts,
    output bre_pkg::bre_ctl_t ctl
);
    import bre_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEQ,
        ST_ADJ,
        ST_FRESH,
        ST_SCAN,
        ST_EMIT,
        ST_CONN,
        ST_ERR
    } state_t;

    state_t state_reg, state_next;
    logic   conn_mode_reg, conn_mode_next;
    logic   accept;

    assign item_ready = (state_reg == ST_IDLE);
    assign accept     = item_valid && item_ready;

    // Next state and datapath commands
    always_comb
    begin
        state_next     = state_reg;
        conn_mode_next = conn_mode_reg;
        ctl            = '0;
        ctl.out_kind   = OUT_NODE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (sts.cmd)
                        CMD_LOAD:
                        begin
                            ctl.load_adj = 1'b1;
                        end
                        CMD_TRAVERSE:
                        begin
                            if (sts.start_ok)
                            begin
                                ctl.init_run   = 1'b1;
                                conn_mode_next = 1'b0;
                                state_next     = ST_DEQ;
                            end
                            else
                            begin
                                state_next = ST_ERR;
                            end
                        end
                        CMD_CONNECT:
                        begin
                            ctl.init_run   = 1'b1;
                            ctl.src_zero   = 1'b1;
                            conn_mode_next = 1'b1;
                            state_next     = ST_DEQ;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DEQ:
            begin
                ctl.deq    = 1'b1;
                state_next = ST_ADJ;
            end
            ST_ADJ:
            begin
                ctl.latch_cur = 1'b1;
                state_next    = ST_FRESH;
            end
            ST_FRESH:
            begin
                ctl.take_row = 1'b1;
                state_next   = ST_SCAN;
            end
            ST_SCAN:
            begin
                // Push one new neighbor per cycle, then finish this node
                if (!sts.pending_zero)
                begin
                    ctl.push = 1'b1;
                end
                else if (!conn_mode_reg)
                begin
                    state_next = ST_EMIT;
                end
                else if (sts.queue_empty)
                begin
                    state_next = ST_CONN;
                end
                else
                begin
                    state_next = ST_DEQ;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    ctl.load_out = 1'b1;
                    ctl.out_kind = OUT_NODE;
                    state_next   = sts.queue_empty ? ST_IDLE : ST_DEQ;
                end
            end
            ST_CONN:
            begin
                if (sts.out_free)
                begin
                    ctl.load_out = 1'b1;
                    ctl.out_kind = OUT_CONN;
                    state_next   = ST_IDLE;
                end
            end
            ST_ERR:
            begin
                if (sts.out_free)
                begin
                    ctl.load_out = 1'b1;
                    ctl.out_kind = OUT_ERR;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and run mode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            conn_mode_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            conn_mode_reg <= conn_mode_next;
        end
    end

endmodule

// File: hw/rtl/bre_dp.sv
// Datapath of the reachability engine: adjacency RAM, node queue RAM, visited bits,
// neighbor scan and result register. Depends on bre_pkg, bre_ram and the assert header.
`include "bfs_reachability_engine_assert.svh"

module bre_dp #(
    parameter int MAX_NODES = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       node_count_we,
    input  logic [bre_pkg::CNT_W-1:0]  node_count_wdata,
    input  bre_pkg::bre_item_t         item,
    output bre_pkg::bre_result_t       result,
    output logic                       result_valid,
    input  logic                       result_ready,
    input  bre_pkg::bre_ctl_t          ctl,
    output bre_pkg::bre_sts_t          sts
);
    import bre_pkg::*;

    localparam int AW = $clog2(MAX_NODES);
    localparam int PW = $clog2(MAX_NODES + 1);

    logic [CNT_W-1:0]  node_count_reg;
    logic [CNT_W-1:0]  n_eff;
    logic [PW-1:0]     head_reg;
    logic [PW-1:0]     tail_reg;
    logic [ROW_W-1:0]  visited_reg;
    logic [ROW_W-1:0]  pending_reg;
    logic [ROW_W-1:0]  lim_reg;
    logic [ROW_W-1:0]  fresh;
    logic [ROW_W-1:0]  low_bit;
    logic [NODE_W-1:0] push_idx;
    logic [NODE_W-1:0] cur_reg;
    logic [NODE_W-1:0] src;
    bre_result_t       out_reg;
    logic              out_valid_reg;
    logic              queue_empty;
    logic              out_free;
    logic              row_in_range;

    logic              q_we;
    logic [AW-1:0]     q_waddr;
    logic [NODE_W-1:0] q_wdata;
    logic [NODE_W-1:0] q_rdata;
    logic              a_we;
    logic [ROW_W-1:0]  a_rdata;

    // Effective node count, saturated to the array size
    assign n_eff = (node_count_reg > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : node_count_reg;

    assign src          = ctl.src_zero ? '0 : item.start_node;
    assign queue_empty  = (head_reg == tail_reg);
    assign out_free     = !out_valid_reg || result_ready;
    assign row_in_range = ({1'b0, item.row_index} < CNT_W'(MAX_NODES));

    // Neighbors not yet visited and inside the node count
    assign fresh = a_rdata & lim_reg & ~visited_reg;

    // Lowest pending neighbor
    assign low_bit = pending_reg & (~pending_reg + ROW_W'(1));
    always_comb
    begin
        push_idx = '0;
        for (int i = 0; i < ROW_W; i++)
        begin
            if (low_bit[i])
            begin
                push_idx = push_idx | NODE_W'(i);
            end
        end
    end

    // Status back to the controller
    always_comb
    begin
        sts.cmd          = item.command;
        sts.start_ok     = ({1'b0, item.start_node} < n_eff);
        sts.queue_empty  = queue_empty;
        sts.pending_zero = (pending_reg == '0);
        sts.out_free     = out_free;
    end

    // Node queue: seeded on run start, appended during the scan
    assign q_we    = ctl.init_run || ctl.push;
    assign q_waddr = ctl.init_run ? '0 : tail_reg[AW-1:0];
    assign q_wdata = ctl.init_run ? src : push_idx;

    bre_ram #(
        .WIDTH (NODE_W),
        .DEPTH (MAX_NODES)
    ) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .re    (ctl.deq),
        .raddr (head_reg[AW-1:0]),
        .rdata (q_rdata)
    );

    // Adjacency rows: written by load words, read at the dequeued node
    assign a_we = ctl.load_adj && row_in_range;

    bre_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_NODES)
    ) u_adj_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (item.row_index[AW-1:0]),
        .wdata (item.row_bits),
        .re    (ctl.latch_cur),
        .raddr (q_rdata[AW-1:0]),
        .rdata (a_rdata)
    );

    // Control state: node count, queue pointers, visited and pending bits, result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_COUNT_RST;
            head_reg       <= '0;
            tail_reg       <= '0;
            visited_reg    <= '0;
            pending_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (node_count_we)
            begin
                node_count_reg <= node_count_wdata;
            end
            if (ctl.init_run)
            begin
                head_reg    <= '0;
                tail_reg    <= PW'(1);
                visited_reg <= ROW_W'(1) << src;
            end
            else
            begin
                if (ctl.deq)
                begin
                    head_reg <= head_reg + PW'(1);
                end
                if (ctl.push)
                begin
                    tail_reg <= tail_reg + PW'(1);
                end
                if (ctl.take_row)
                begin
                    visited_reg <= visited_reg | fresh;
                end
            end
            if (ctl.take_row)
            begin
                pending_reg <= fresh;
            end
            else if (ctl.push)
            begin
                pending_reg <= pending_reg & ~low_bit;
            end
            if (ctl.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: search mask, current node, result word
    always_ff @(posedge clk)
    begin
        if (ctl.init_run)
        begin
            lim_reg <= low_mask(n_eff);
        end
        if (ctl.latch_cur)
        begin
            cur_reg <= q_rdata;
        end
        if (ctl.load_out)
        begin
            unique case (ctl.out_kind)
                OUT_NODE:
                begin
                    out_reg.node      <= cur_reg;
                    out_reg.last      <= queue_empty;
                    out_reg.connected <= 1'b0;
                    out_reg.error     <= 1'b0;
                end
                OUT_CONN:
                begin
                    out_reg.node      <= '0;
                    out_reg.last      <= 1'b1;
                    out_reg.connected <= ((visited_reg & lim_reg) == lim_reg);
                    out_reg.error     <= 1'b0;
                end
                OUT_ERR:
                begin
                    out_reg.node      <= '0;
                    out_reg.last      <= 1'b1;
                    out_reg.connected <= 1'b0;
                    out_reg.error     <= 1'b1;
                end
                default:
                begin
                    out_reg <= out_reg;
                end
            endcase
        end
    end

    assign result       = out_reg;
    assign result_valid = out_valid_reg;

    `BRE_ASSERT(a_head_not_past_tail, head_reg <= tail_reg, "queue head passed the tail")
    `BRE_ASSERT(a_push_visited, ctl.push |-> visited_reg[q_wdata], "queued node not marked visited")
    `BRE_ASSERT_NEVER(a_pending_unvisited, (pending_reg & ~visited_reg) != '0, "pending node not visited")
    `BRE_ASSERT(a_load_into_free, ctl.load_out |-> out_free, "result loaded over an untaken word")

endmodule
